/* hdl/mpd_pkg.sv */
`timescale 1ns / 1ps
// Package for the Morse pulse decoder: payload and control structs,
// result and register codes, and the character pattern table. No dependencies.
package mpd_pkg;

	localparam int MAX_ELEMENTS = 5;
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
	localparam int STAMP_W      = 16;
	localparam int CODE_W       = 6;
	localparam int NUM_CHARS    = 36;

	// result kinds
	localparam logic [1:0] RES_DOT  = 2'd0;
	localparam logic [1:0] RES_DASH = 2'd1;
	localparam logic [1:0] RES_CHAR = 2'd2;

	localparam logic [CODE_W-1:0] NO_MATCH = 6'd36;

	// input kinds
	localparam logic KIND_EDGE = 1'b0;
	localparam logic KIND_POLL = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_DOT_MIN   = 2'd0;
	localparam logic [1:0] REG_DASH_MIN  = 2'd1;
	localparam logic [1:0] REG_DASH_MAX  = 2'd2;
	localparam logic [1:0] REG_GAP_LIMIT = 2'd3;

	// configuration reset values
	localparam logic [STAMP_W-1:0] DOT_MIN_RST   = 16'd468;
	localparam logic [STAMP_W-1:0] DASH_MIN_RST  = 16'd3125;
	localparam logic [STAMP_W-1:0] DASH_MAX_RST  = 16'd6250;
	localparam logic [STAMP_W-1:0] GAP_LIMIT_RST = 16'd6250;

	typedef struct packed {
		logic               kind;
		logic [STAMP_W-1:0] stamp;
	} mpd_in_t;

	typedef struct packed {
		logic [1:0]        result_kind;
		logic [CODE_W-1:0] char_code;
	} mpd_out_t;

	typedef struct packed {
		logic [STAMP_W-1:0] dot_min;
		logic [STAMP_W-1:0] dash_min;
		logic [STAMP_W-1:0] dash_max;
		logic [STAMP_W-1:0] gap_limit;
	} mpd_cfg_t;

	// result request from the keyer
	typedef struct packed {
		logic       push;
		logic [1:0] result_kind;
	} mpd_event_t;

	// element buffer contents; bit k set = element k is a dash
	typedef struct packed {
		logic [CNT_W-1:0]        count;
		logic [MAX_ELEMENTS-1:0] elems;
	} mpd_elem_buf_t;

	// pattern lengths, A-Z then 1-9 then 0
	localparam logic [CNT_W-1:0] PAT_LEN [NUM_CHARS] = '{
		3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
		3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
		3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
		3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
		3'd5, 3'd5, 3'd5, 3'd5, 3'd5
	};

	// pattern elements, bit k = element k, 1 = dash, zero above the length
	localparam logic [MAX_ELEMENTS-1:0] PAT_BITS [NUM_CHARS] = '{
		5'b00010, 5'b00001, 5'b00101, 5'b00001, 5'b00000, 5'b00100,
		5'b00011, 5'b00000, 5'b00000, 5'b01110, 5'b00101, 5'b00010,
		5'b00011, 5'b00001, 5'b00111, 5'b00110, 5'b01011, 5'b00010,
		5'b00000, 5'b00001, 5'b00100, 5'b01000, 5'b00110, 5'b01001,
		5'b01101, 5'b00011,
		5'b11110, 5'b11100, 5'b11000, 5'b10000, 5'b00000,
		5'b00001, 5'b00011, 5'b00111, 5'b01111, 5'b11111
	};

endpackage

/* hdl/mpd_keyer.sv */
`timescale 1ns / 1ps
// Key edge tracking, press width classification, element buffer and gap check.
// Depends on mpd_pkg.
module mpd_keyer import mpd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  mpd_cfg_t      cfg,
	input  logic          accept,
	input  mpd_in_t       item,
	output mpd_event_t    evt,
	output mpd_elem_buf_t elem_buf
);

	logic                    open_q;
	logic [STAMP_W-1:0]      start_q;
	logic [STAMP_W-1:0]      release_q;
	logic [CNT_W-1:0]        count_q;
	logic [MAX_ELEMENTS-1:0] elems_q;

	logic [STAMP_W-1:0] width;
	logic [STAMP_W-1:0] gap;
	logic               is_dot;
	logic               is_dash;
	logic               is_edge;
	logic               release_hit;
	logic               char_done;
	logic               full;

	// classify the press width and check the idle gap
	always_comb begin
		width       = item.stamp - start_q;
		gap         = item.stamp - release_q;
		is_dot      = (width >= cfg.dot_min) && (width < cfg.dash_min);
		is_dash     = !is_dot && (width >= cfg.dash_min) && (width <= cfg.dash_max);
		is_edge     = accept && (item.kind == KIND_EDGE);
		release_hit = is_edge && open_q && (is_dot || is_dash);
		char_done   = accept && (item.kind == KIND_POLL) && !open_q
			&& (count_q != '0) && (gap > cfg.gap_limit);
		full        = (count_q == CNT_W'(MAX_ELEMENTS));
	end

	// result request
	always_comb begin
		evt.push        = release_hit || char_done;
		evt.result_kind = char_done ? RES_CHAR : (is_dash ? RES_DASH : RES_DOT);
		elem_buf.count  = count_q;
		elem_buf.elems  = elems_q;
	end

	// press tracking and element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q    <= 1'b0;
			start_q   <= '0;
			release_q <= '0;
			count_q   <= '0;
		end else begin
			if (is_edge) begin
				open_q <= !open_q;
				if (!open_q) begin
					start_q <= item.stamp;
				end else begin
					release_q <= item.stamp;
				end
			end
			if (char_done) begin
				count_q <= '0;
			end else if (release_hit && !full) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// element store; entries at or above the count are don't-care
	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_ELEMENTS; k++) begin
			if (release_hit && (count_q == CNT_W'(k))) begin
				elems_q[k] <= is_dash;
			end
		end
	end

	// assertions
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ELEMENTS))
		else $error("element count beyond buffer depth");

	a_char_clears: assert property (@(posedge clk) disable iff (!arst_n)
		char_done |=> (count_q == '0))
		else $error("buffer not cleared after character");

	a_push_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		evt.push |-> accept)
		else $error("result request without an accepted item");

endmodule

/* hdl/mpd_match.sv */
`timescale 1ns / 1ps
// Parallel compare of the element buffer against the 36-entry character table.
// Depends on mpd_pkg.
module mpd_match import mpd_pkg::*; (
	input  mpd_elem_buf_t     elem_buf,
	output logic [CODE_W-1:0] char_code
);

	logic [MAX_ELEMENTS-1:0] mask;
	logic [MAX_ELEMENTS-1:0] masked;

	// keep only the elements below the count
	always_comb begin
		for (int k = 0; k < MAX_ELEMENTS; k++) begin
			mask[k] = (CNT_W'(k) < elem_buf.count);
		end
		masked = elem_buf.elems & mask;
	end

	// priority pick of the lowest matching entry
	always_comb begin
		char_code = NO_MATCH;
		for (int i = NUM_CHARS - 1; i >= 0; i--) begin
			if ((elem_buf.count == PAT_LEN[i]) && (masked == PAT_BITS[i])) begin
				char_code = CODE_W'(i);
			end
		end
	end

endmodule

/* hdl/mpd_outbuf.sv */
`timescale 1ns / 1ps
// Result register with a skid stage so the input side can take one more result on a stall.
// Depends on mpd_pkg.
module mpd_outbuf import mpd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  mpd_out_t push_data,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output mpd_out_t out_data
);

	logic     head_v_q;
	logic     skid_v_q;
	mpd_out_t head_q;
	mpd_out_t skid_q;
	logic     pop;

	assign pop       = head_v_q && out_ready;
	assign in_ready  = !skid_v_q;
	assign out_valid = head_v_q;
	assign out_data  = head_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (skid_v_q) begin
				if (pop) begin
					skid_v_q <= 1'b0;
				end
			end else if (!head_v_q || pop) begin
				head_v_q <= push;
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				head_q <= skid_q;
			end
		end else if (!head_v_q || pop) begin
			if (push) begin
				head_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	// assertions
	a_skid_behind_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> head_v_q)
		else $error("skid entry held with empty head");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_v_q)
		else $error("result pushed into a full buffer");

endmodule

/* hdl/morse_pulse_decoder.sv */
`timescale 1ns / 1ps
// Morse pulse decoder top level: config registers, keyer, matcher, result buffer.
// Depends on mpd_pkg, mpd_keyer, mpd_match, mpd_outbuf.
//
//  channel | signals                         | direction | request
//  --------+---------------------------------+-----------+---------------------------
//  in      | in_valid, in_ready, in_data     | to block  | key edge or time poll
//  out     | out_valid, out_ready, out_data  | from block| dot, dash or character
//  cfg     | cfg_we, cfg_index, cfg_data     | to block  | register write, no wait
//
// One request per cycle while in_ready is high. A result goes into the result register,
// or into the skid entry when out stalls. The keyer state and the result register bound
// the path: width subtract and compare, or the 36-entry table compare, lie between them.
// Reset clears the press state, element count, result flags and restores registers.
// A stalled out side is absorbed by one skid entry; in_ready drops once it fills.
module morse_pulse_decoder import mpd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mpd_in_t            in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output mpd_out_t           out_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [STAMP_W-1:0] cfg_data
);

	mpd_cfg_t          cfg_q;
	logic              accept;
	mpd_event_t        evt;
	mpd_elem_buf_t     elem_buf;
	logic [CODE_W-1:0] match_code;
	mpd_out_t          res;

	assign accept = in_valid && in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dot_min   <= DOT_MIN_RST;
			cfg_q.dash_min  <= DASH_MIN_RST;
			cfg_q.dash_max  <= DASH_MAX_RST;
			cfg_q.gap_limit <= GAP_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DOT_MIN:   cfg_q.dot_min   <= cfg_data;
				REG_DASH_MIN:  cfg_q.dash_min  <= cfg_data;
				REG_DASH_MAX:  cfg_q.dash_max  <= cfg_data;
				REG_GAP_LIMIT: cfg_q.gap_limit <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	mpd_keyer u_keyer (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.accept   (accept),
		.item     (in_data),
		.evt      (evt),
		.elem_buf (elem_buf)
	);

	mpd_match u_match (
		.elem_buf  (elem_buf),
		.char_code (match_code)
	);

	// result item; char_code is zero for dot and dash
	always_comb begin
		res.result_kind = evt.result_kind;
		res.char_code   = (evt.result_kind == RES_CHAR) ? match_code : '0;
	end

	mpd_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (evt.push),
		.push_data (res),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// assertions
	a_code_only_on_char: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.result_kind != RES_CHAR)) |-> (out_data.char_code == '0))
		else $error("character code on a dot or dash result");

endmodule
